FILE: src/tmbv_pkg.sv
package tmbv_pkg;

   localparam int SAMPLE_W = 12;
   localparam int MV_W     = 15;

   localparam int BATCH_SIZE_DEF    = 20;
   localparam int TRIM_EACH_END_DEF = 5;

   // mean divider: dividend covers a full batch sum, divisor covers the kept count
   localparam int DIV_W = 24;
   localparam int DEN_W = 12;

   // constant divisions by reciprocal multiply, exact for every mean up to 4095:
   //   3300 * m / 4095 = 220 * m / 273  ->  (m * SCALE_MUL) >> SCALE_SH
   //   140 * m / 2296  = 5 * m / 82     ->  (m * COMP_MUL) >> COMP_SH
   //   1200 * s / 185  = 240 * s / 37   ->  (s * VOLT_MUL) >> VOLT_SH
   localparam int          SCALE_SH  = 28;
   localparam logic [27:0] SCALE_MUL = 28'd216321820;
   localparam int          COMP_SH   = 21;
   localparam logic [16:0] COMP_MUL  = 17'd127880;
   localparam int          VOLT_SH   = 25;
   localparam logic [27:0] VOLT_MUL  = 28'd217650480;
   localparam int          COMP_W    = 8;

endpackage

FILE: src/trimmed_mean_battery_voltage.sv
// Trimmed-mean battery voltage filter. Each batch of BATCH_SIZE samples is
// taken at one beat per cycle into a sample memory with one write port and
// one read port. After the last beat of a batch the input stalls while the
// block ranks every entry against all others by sweeping the memory (one
// read per cycle, registered read data), sums the nonzero entries whose rank
// lies outside the TRIM_EACH_END smallest and largest, divides the sum by
// the kept count on a bit-serial divider of DIV_W steps, and scales the mean
// to millivolts by reciprocal multiplies in a scale step and a final step.
// A batch with no kept nonzero entry skips the divider. One millivolt beat
// is given per batch; it is held in an output register, and the next batch
// is collected while it waits to be taken. The final step stalls until that
// beat is gone.
module trimmed_mean_battery_voltage
   import tmbv_pkg::*;
#(
   parameter int BATCH_SIZE    = BATCH_SIZE_DEF,
   parameter int TRIM_EACH_END = TRIM_EACH_END_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [MV_W-1:0]     rsp_millivolts
);

   localparam int IDX_W   = $clog2(BATCH_SIZE);
   localparam int CNT_W   = $clog2(BATCH_SIZE + 1);
   localparam int SUM_W   = $clog2(BATCH_SIZE * 4095 + 1);
   localparam int STEP_W  = $clog2(DIV_W);
   localparam int KEEP_LO = TRIM_EACH_END;
   localparam int KEEP_HI = (BATCH_SIZE > TRIM_EACH_END) ? BATCH_SIZE - TRIM_EACH_END : 0;
   localparam int PROD_W      = SAMPLE_W + 28;
   localparam int COMP_PROD_W = SAMPLE_W + 17;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BATCH_SIZE - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_LOAD_KEY,
      ST_KEY,
      ST_SWEEP,
      ST_TAIL,
      ST_ACCUM,
      ST_START,
      ST_DIV,
      ST_SCALE,
      ST_VOLT
   } state_type;

   state_type             state_ff;
   logic [SAMPLE_W-1:0]   mem_ff [BATCH_SIZE];
   logic [SAMPLE_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_idx_ff;
   logic [IDX_W-1:0]      i_ff;
   logic [IDX_W-1:0]      j_ff;
   logic [IDX_W-1:0]      pend_idx_ff;
   logic                  pend_ff;
   logic [SAMPLE_W-1:0]   key_ff;
   logic [IDX_W-1:0]      rank_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIV_W-1:0]      quo_ff;
   logic [DEN_W-1:0]      rem_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [SAMPLE_W-1:0]   scaled_ff;
   logic [COMP_W-1:0]     comp_ff;
   logic                  rsp_valid_ff;
   logic [MV_W-1:0]       rsp_mv_ff;

   logic                  req_accept;
   logic                  ranks_below;
   logic                  keep;
   logic [DEN_W:0]        rem_sh;
   logic                  rem_fits;
   logic [DEN_W:0]        rem_diff;
   logic [PROD_W-1:0]     scale_prod;
   logic [COMP_PROD_W-1:0] comp_prod;
   logic [PROD_W-1:0]     volt_prod;
   logic                  out_load;

   assign req_stall      = (state_ff != ST_COLLECT);
   assign req_accept     = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_millivolts = rsp_mv_ff;

   assign rd_addr = (state_ff == ST_LOAD_KEY) ? i_ff : j_ff;

   // stable ordering: equal values rank by memory index
   assign ranks_below = pend_ff &&
                        ((rd_data_ff < key_ff) ||
                         ((rd_data_ff == key_ff) && (pend_idx_ff < i_ff)));

   assign keep = (int'(rank_ff) >= KEEP_LO) && (int'(rank_ff) < KEEP_HI) &&
                 (key_ff != '0);

   assign rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_fits = (rem_sh >= {1'b0, den_ff});
   assign rem_diff = rem_sh - {1'b0, den_ff};

   assign scale_prod = PROD_W'(quo_ff[SAMPLE_W-1:0]) * PROD_W'(SCALE_MUL);
   assign comp_prod  = COMP_PROD_W'(quo_ff[SAMPLE_W-1:0]) * COMP_PROD_W'(COMP_MUL);
   assign volt_prod  = PROD_W'(scaled_ff) * PROD_W'(VOLT_MUL);

   // hold the last step until the previous beat is gone
   assign out_load = (state_ff == ST_VOLT) && (!rsp_valid_ff || !rsp_stall);

   // sample memory: writes only while collecting; the read port is clocked always, its data is used while ranking
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mem_ff[wr_idx_ff] <= req_sample;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         wr_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_COLLECT: begin
               if (req_accept) begin
                  if (wr_idx_ff == LAST_IDX) begin
                     wr_idx_ff <= '0;
                     i_ff      <= '0;
                     sum_ff    <= '0;
                     cnt_ff    <= '0;
                     state_ff  <= ST_LOAD_KEY;
                  end else begin
                     wr_idx_ff <= wr_idx_ff + 1'b1;
                  end
               end
            end

            ST_LOAD_KEY: begin
               state_ff <= ST_KEY;
            end

            ST_KEY: begin
               key_ff   <= rd_data_ff;
               rank_ff  <= '0;
               j_ff     <= '0;
               pend_ff  <= 1'b0;
               state_ff <= ST_SWEEP;
            end

            ST_SWEEP: begin
               if (ranks_below) begin
                  rank_ff <= rank_ff + 1'b1;
               end
               pend_ff     <= 1'b1;
               pend_idx_ff <= j_ff;
               if (j_ff == LAST_IDX) begin
                  state_ff <= ST_TAIL;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end

            ST_TAIL: begin
               // drain the last read of the sweep
               if (ranks_below) begin
                  rank_ff <= rank_ff + 1'b1;
               end
               pend_ff  <= 1'b0;
               state_ff <= ST_ACCUM;
            end

            ST_ACCUM: begin
               if (keep) begin
                  sum_ff <= sum_ff + SUM_W'(key_ff);
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (i_ff == LAST_IDX) begin
                  state_ff <= ST_START;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_LOAD_KEY;
               end
            end

            ST_START: begin
               if (cnt_ff == '0) begin
                  // nothing kept: skip the divider and give zero
                  scaled_ff <= '0;
                  comp_ff   <= '0;
                  state_ff  <= ST_VOLT;
               end else begin
                  quo_ff    <= DIV_W'(sum_ff);
                  den_ff    <= DEN_W'(cnt_ff);
                  rem_ff    <= '0;
                  step_ff   <= '0;
                  state_ff  <= ST_DIV;
               end
            end

            ST_DIV: begin
               if (rem_fits) begin
                  rem_ff <= rem_diff[DEN_W-1:0];
               end else begin
                  rem_ff <= rem_sh[DEN_W-1:0];
               end
               quo_ff <= {quo_ff[DIV_W-2:0], rem_fits};
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_SCALE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end

            ST_SCALE: begin
               scaled_ff <= scale_prod[SCALE_SH +: SAMPLE_W];
               comp_ff   <= comp_prod[COMP_SH +: COMP_W];
               state_ff  <= ST_VOLT;
            end

            ST_VOLT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mv_ff    <= volt_prod[VOLT_SH +: MV_W] + MV_W'(comp_ff);
                  state_ff     <= ST_COLLECT;
               end
            end

            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("divider started with zero divisor");

   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_VOLT))
      else $error("result beat raised outside final step");

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= BATCH_SIZE || state_ff == ST_COLLECT)
      else $error("kept count exceeds batch size");
`endif

endmodule
